// ----- rtl/core/dtq_pkg.sv -----
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and codes of the deadline timer queue
// Request kinds, result status codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 64;
  localparam int unsigned HDL_W           = 16;
  localparam int unsigned TIME_W          = 48;
  localparam int unsigned ENTRY_W         = HDL_W + TIME_W;
  localparam logic [31:0] IDLE_WAIT_RST   = 32'd1000;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_POP    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_QUERY  = 2'd3
  } dtq_req_t;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_NONE = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_DECIDE,
    S_COMPACT,
    S_DONE
  } dtq_state_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [HDL_W-1:0]  ehandle;
    logic [TIME_W-1:0] wait_time;
  } dtq_res_t;

endpackage

// ----- rtl/core/dtq_mem.sv -----
// ----------------------------------------------------------------------------
// dtq_mem: timer entry storage
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module dtq_mem #(
  parameter int unsigned DEPTH = dtq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [dtq_pkg::ENTRY_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [dtq_pkg::ENTRY_W-1:0] rdata
);
  import dtq_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/dtq_alu.sv -----
// ----------------------------------------------------------------------------
// dtq_alu: shared deadline subtractor
// Computes a - b over the time width with a borrow flag for a < b.
// ----------------------------------------------------------------------------
module dtq_alu (
  input  logic [dtq_pkg::TIME_W-1:0] a,
  input  logic [dtq_pkg::TIME_W-1:0] b,
  output logic [dtq_pkg::TIME_W-1:0] diff,
  output logic                       borrow
);
  import dtq_pkg::*;

  logic [TIME_W:0] sub;

  assign sub    = {1'b0, a} - {1'b0, b};
  assign diff   = sub[TIME_W-1:0];
  assign borrow = sub[TIME_W];

endmodule

// ----- rtl/core/dtq_seq.sv -----
// ----------------------------------------------------------------------------
// dtq_seq: request sequencer
// Walks the entry memory to find the earliest deadline and to compact the
// table after a pop or a remove, using the shared subtractor for every deadline compare.
// ----------------------------------------------------------------------------
module dtq_seq #(
  parameter int unsigned DEPTH = dtq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_req,
  input  logic [dtq_pkg::HDL_W-1:0]   in_hdl,
  input  logic [dtq_pkg::TIME_W-1:0]  in_dl,
  input  logic [dtq_pkg::TIME_W-1:0]  in_now,
  input  logic [31:0]                 idle_wait,
  input  logic                        out_free,
  output logic                        res_valid,
  output dtq_pkg::dtq_res_t           res,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [dtq_pkg::ENTRY_W-1:0] mem_wdata,
  output logic [AW-1:0]               mem_raddr,
  input  logic [dtq_pkg::ENTRY_W-1:0] mem_rdata,
  output logic [dtq_pkg::TIME_W-1:0]  alu_a,
  output logic [dtq_pkg::TIME_W-1:0]  alu_b,
  input  logic [dtq_pkg::TIME_W-1:0]  alu_diff,
  input  logic                        alu_borrow
);
  import dtq_pkg::*;

  dtq_state_t        state_r, state_nxt;
  dtq_req_t          req_r, req_nxt;
  logic [HDL_W-1:0]  hdl_r, hdl_nxt;
  logic [TIME_W-1:0] dl_r, dl_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     iss_r, iss_nxt;
  logic [CW-1:0]     wptr_r, wptr_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pend_idx_r, pend_idx_nxt;
  logic [AW-1:0]     best_idx_r, best_idx_nxt;
  logic [TIME_W-1:0] best_dl_r, best_dl_nxt;
  logic [HDL_W-1:0]  best_hdl_r, best_hdl_nxt;
  dtq_res_t          res_r, res_nxt;

  logic [TIME_W-1:0] rd_dl;
  logic [HDL_W-1:0]  rd_hdl;
  logic              walk_done;
  logic              due;
  logic              keep;
  dtq_req_t          in_kind;

  assign rd_dl     = mem_rdata[TIME_W-1:0];
  assign rd_hdl    = mem_rdata[ENTRY_W-1:TIME_W];
  assign walk_done = (iss_r == count_r) && !pend_r;
  assign due       = alu_borrow || (alu_diff == '0);
  assign in_kind   = dtq_req_t'(in_req);
  assign in_ready  = (state_r == S_IDLE);
  assign res       = res_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            REQ_ADD:    state_nxt = S_ADD;
            REQ_REMOVE: state_nxt = S_COMPACT;
            default:    state_nxt = (count_r == '0) ? S_DONE : S_SCAN;
          endcase
        end
      end
      S_ADD:     state_nxt = S_DONE;
      S_SCAN:    if (walk_done) state_nxt = S_DECIDE;
      S_DECIDE:  state_nxt = (req_r == REQ_POP && due) ? S_COMPACT : S_DONE;
      S_COMPACT: if (walk_done) state_nxt = S_DONE;
      S_DONE:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory and subtractor controls.
  always_comb begin
    req_nxt      = req_r;
    hdl_nxt      = hdl_r;
    dl_nxt       = dl_r;
    now_nxt      = now_r;
    count_nxt    = count_r;
    iss_nxt      = iss_r;
    wptr_nxt     = wptr_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    best_idx_nxt = best_idx_r;
    best_dl_nxt  = best_dl_r;
    best_hdl_nxt = best_hdl_r;
    res_nxt      = res_r;
    mem_we       = 1'b0;
    mem_waddr    = wptr_r[AW-1:0];
    mem_wdata    = mem_rdata;
    mem_raddr    = iss_r[AW-1:0];
    alu_a        = rd_dl;
    alu_b        = best_dl_r;
    res_valid    = 1'b0;
    keep         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_kind;
          hdl_nxt  = in_hdl;
          dl_nxt   = in_dl;
          now_nxt  = in_now;
          iss_nxt  = '0;
          wptr_nxt = '0;
          pend_nxt = 1'b0;
          res_nxt  = '{status: STAT_DONE, ehandle: '0, wait_time: '0};
          if (count_r == '0 && in_kind == REQ_POP) begin
            res_nxt.status = STAT_NONE;
          end
          if (count_r == '0 && in_kind == REQ_QUERY) begin
            res_nxt.status    = STAT_NONE;
            res_nxt.wait_time = TIME_W'(idle_wait);
          end
        end
      end

      S_ADD: begin
        if (count_r < CW'(DEPTH)) begin
          mem_we    = 1'b1;
          mem_waddr = count_r[AW-1:0];
          mem_wdata = {hdl_r, dl_r};
          count_nxt = count_r + CW'(1);
        end else begin
          res_nxt.status = STAT_FULL;
        end
      end

      S_SCAN: begin
        pend_nxt     = (iss_r < count_r);
        pend_idx_nxt = iss_r[AW-1:0];
        if (iss_r < count_r) begin
          iss_nxt = iss_r + CW'(1);
        end
        // Strictly earlier wins, so the first of equal deadlines stays best.
        if (pend_r && (pend_idx_r == '0 || alu_borrow)) begin
          best_idx_nxt = pend_idx_r;
          best_dl_nxt  = rd_dl;
          best_hdl_nxt = rd_hdl;
        end
      end

      S_DECIDE: begin
        alu_a = best_dl_r;
        alu_b = now_r;
        if (req_r == REQ_QUERY) begin
          res_nxt.wait_time = due ? '0 : alu_diff;
        end else if (due) begin
          res_nxt.ehandle = best_hdl_r;
          iss_nxt         = CW'(best_idx_r);
          wptr_nxt        = CW'(best_idx_r);
          pend_nxt        = 1'b0;
        end else begin
          res_nxt.status = STAT_NONE;
        end
      end

      S_COMPACT: begin
        pend_nxt     = (iss_r < count_r);
        pend_idx_nxt = iss_r[AW-1:0];
        if (iss_r < count_r) begin
          iss_nxt = iss_r + CW'(1);
        end
        if (req_r == REQ_REMOVE) begin
          keep = (rd_hdl != hdl_r);
        end else begin
          keep = (pend_idx_r != best_idx_r);
        end
        if (pend_r && keep) begin
          mem_we   = 1'b1;
          wptr_nxt = wptr_r + CW'(1);
        end
        if (walk_done) begin
          count_nxt = wptr_r;
        end
      end

      S_DONE: begin
        res_valid = out_free;
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    hdl_r      <= hdl_nxt;
    dl_r       <= dl_nxt;
    now_r      <= now_nxt;
    iss_r      <= iss_nxt;
    wptr_r     <= wptr_nxt;
    pend_idx_r <= pend_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_dl_r  <= best_dl_nxt;
    best_hdl_r <= best_hdl_nxt;
    res_r      <= res_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds table depth");

  a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> out_free)
    else $error("result issued while output register is occupied");

  a_compact_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMPACT && mem_we) |-> (wptr_r < count_r))
    else $error("compaction write beyond the live entries");

  a_count_only_shrinks_in_compact: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMPACT) |=> (count_r <= $past(count_r)))
    else $error("entry count grew during compaction");
`endif

endmodule

// ----- rtl/core/deadline_timer_queue_core.sv -----
// ----------------------------------------------------------------------------
// deadline_timer_queue_core: bounded table of pending timers
// Stream-in requests, stream-out one result each, APB register for idle wait.
// ----------------------------------------------------------------------------
// Each request is one input transaction and yields exactly one result
// transaction. Timers are kept in insertion order in a single-port-write,
// registered-read memory, and one sequencer walks that memory one entry per
// cycle with a single shared 48-bit subtractor doing every deadline compare.
// An add writes the new entry at the end of the table. A query scans all
// pending timers for the earliest deadline and reports its wait; a remove
// compacts the table, dropping entries with the given handle; a due pop scans
// for the earliest deadline, closes the gap behind the popped entry and then
// hands over the result. The input is not ready while a request is in
// progress; a finished result sits in an output register, so the next
// request can be accepted while it waits.
// Ties between equal deadlines go to the entry inserted first. The idle wait
// register (address 0, reset 1000) is what a query reports when the table is
// empty; write it only while no transaction is in progress.
// ----------------------------------------------------------------------------
module deadline_timer_queue_core #(
  parameter int unsigned QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // Request channel.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,   // handle[15:0], deadline[63:16], now[111:64]
  input  logic [1:0]   in_tuser,   // req_type[1:0]
  // Result channel.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // expired_handle[15:0], wait_time[63:16]
  output logic [1:0]   out_tuser,  // status[1:0]
  // Configuration port.
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import dtq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [2:0]  ADDR_IDLE_WAIT = 3'd0;

  // The only register sits at byte address 0; other addresses are ignored.
  logic [31:0] idle_wait_r, idle_wait_nxt;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == ADDR_IDLE_WAIT) ? idle_wait_r : '0;

  always_comb begin
    idle_wait_nxt = idle_wait_r;
    if (cfg_wr && cfg_paddr == ADDR_IDLE_WAIT) begin
      idle_wait_nxt = cfg_pwdata;
    end
  end

  // Output register: holds a finished result until the consumer takes it.
  logic        out_valid_r, out_valid_nxt;
  dtq_res_t    out_res_r, out_res_nxt;
  logic        out_free;
  logic        res_valid;
  dtq_res_t    res;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_wait_r <= IDLE_WAIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      idle_wait_r <= idle_wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.wait_time, out_res_r.ehandle};
  assign out_tuser  = out_res_r.status;

  // Sequencer, entry memory and the shared subtractor.
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [ENTRY_W-1:0]  mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [ENTRY_W-1:0]  mem_rdata;
  logic [TIME_W-1:0]   alu_a;
  logic [TIME_W-1:0]   alu_b;
  logic [TIME_W-1:0]   alu_diff;
  logic                alu_borrow;

  dtq_seq #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_req     (in_tuser),
    .in_hdl     (in_tdata[15:0]),
    .in_dl      (in_tdata[63:16]),
    .in_now     (in_tdata[111:64]),
    .idle_wait  (idle_wait_r),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .alu_a      (alu_a),
    .alu_b      (alu_b),
    .alu_diff   (alu_diff),
    .alu_borrow (alu_borrow)
  );

  dtq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dtq_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .diff   (alu_diff),
    .borrow (alu_borrow)
  );

endmodule
